// ===== rtl/bfiq_pkg.sv =====
// shared constants, types and codes of the bloom filter insert/query block
package bfiq_pkg;

    localparam int MAX_LOG_BITS = 16;
    localparam int MIN_LOG_BITS = 9;
    localparam int MAX_PROBES   = 32;

    localparam int FP_W        = 64;
    localparam int PROBE_W     = 6;
    localparam int LOG_W       = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 6;

    localparam int IDX_W   = MAX_LOG_BITS;
    localparam int WORD_W  = 64;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int WORDS   = (2 ** IDX_W) / WORD_W;
    localparam int WADDR_W = $clog2(WORDS);
    localparam int CNT_W   = $clog2(MAX_PROBES + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int CAPACITY    = QUEUE_DEPTH + 2;

    localparam int IN_TDATA_W  = ((2 * FP_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_PROBE_COUNT = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_LOG_BITS    = CFG_INDEX_W'(1);

    localparam logic ACT_QUERY = 1'b0;
    localparam logic ACT_ADD   = 1'b1;

    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] base;
        logic [IDX_W-1:0] stride;
        logic [IDX_W-1:0] mask;
        logic [CNT_W-1:0] probes;
    } bfiq_job_t;

endpackage

// ===== rtl/bloom_filter_insert_query.sv =====
// top level of the bloom filter insert/query block
//
// input channel s_*: one beat per item; s_tuser is the action (query or add),
// s_tdata carries the two fingerprint halves. output channel m_*: one beat
// per item with the answer in bit 0, in input order.
// configuration: cfg_we/cfg_index/cfg_data write probe count (index 0) and
// log2 of the filter size (index 1); write only while the block is idle.
// the front end clamps the config values and turns each beat into a probe job
// held in a two-entry queue; the back end walks the probes over a 64-bit-wide
// bit store, one store word read per cycle, with the read-modify-write of an
// add overlapped with the next read.
// the back end takes a new item from the queue only after the result of the
// last one is registered and the result register is free; a zero-probe item
// goes straight to the result register, one per cycle while m_tready holds.
// the single store read port limits the engine to one probe per cycle.
// reset: registers clear at once, then a clearing pass zeroes all 1024 store
// words; s_tready stays low until it ends (config writes still work).
// a stalled m_tready holds the result and keeps the back end idle; up to two
// more beats are accepted into the queue, after which s_tready drops.
module bloom_filter_insert_query
    import bfiq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tuser,   // action
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // fp_low, fp_high
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // answer, zero fill
);

    logic      clear_done;
    logic      push_valid;
    logic      push_ready;
    bfiq_job_t push_job;
    logic      pop_valid;
    logic      pop_ready;
    bfiq_job_t pop_job;

    // config and beat classification
    bfiq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .clear_done (clear_done),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // decouples accepting beats from running probes
    bfiq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // bit store, probe engine and result register
    bfiq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job),
        .clear_done (clear_done),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== rtl/bfiq_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
module bfiq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/bfiq_front.sv =====
// front end: configuration registers and classification of incoming beats
module bfiq_front
    import bfiq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tuser,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   clear_done,
    output logic                   push_valid,
    input  logic                   push_ready,
    output bfiq_job_t              push_job
);

    logic [PROBE_W-1:0] probe_count_reg;
    logic [LOG_W-1:0]   log_bits_reg;
    logic [LOG_W-1:0]   eff_log;
    logic [CNT_W-1:0]   eff_probes;
    logic [IDX_W-1:0]   mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_count_reg <= PROBE_W'(1);
            log_bits_reg    <= LOG_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PROBE_COUNT: probe_count_reg <= cfg_data[PROBE_W-1:0];
                REG_LOG_BITS:    log_bits_reg    <= cfg_data[LOG_W-1:0];
                default:         ;
            endcase
        end
    end

    // clamp the bit count and the probe count to the supported ranges
    always_comb
    begin
        if (log_bits_reg < LOG_W'(MIN_LOG_BITS))
            eff_log = LOG_W'(MIN_LOG_BITS);
        else if (log_bits_reg > LOG_W'(MAX_LOG_BITS))
            eff_log = LOG_W'(MAX_LOG_BITS);
        else
            eff_log = log_bits_reg;

        if (probe_count_reg > PROBE_W'(MAX_PROBES))
            eff_probes = CNT_W'(MAX_PROBES);
        else
            eff_probes = CNT_W'(probe_count_reg);

        for (int b = 0; b < IDX_W; b++)
            mask[b] = (LOG_W'(b) < eff_log);
    end

    // only the low index bits of the fingerprint halves reach the store
    assign push_job.action = s_tuser;
    assign push_job.base   = s_tdata[IDX_W-1:0];
    assign push_job.stride = s_tdata[FP_W+IDX_W-1:FP_W];
    assign push_job.mask   = mask;
    assign push_job.probes = eff_probes;

    assign s_tready   = push_ready && clear_done;
    assign push_valid = s_tvalid && clear_done;

endmodule

// ===== rtl/bfiq_queue.sv =====
// short job queue between the front end and the probe engine
module bfiq_queue
    import bfiq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_valid,
    output logic      push_ready,
    input  bfiq_job_t push_job,
    output logic      pop_valid,
    input  logic      pop_ready,
    output bfiq_job_t pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    bfiq_job_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (fill_reg != FILL_W'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            return '0;
        else
            return p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                fill_reg <= fill_reg + FILL_W'(1);
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/bfiq_back.sv =====
// back end: clearing pass, probe engine over the bit store, result register
module bfiq_back
    import bfiq_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pop_valid,
    output logic                   pop_ready,
    input  bfiq_job_t              pop_job,
    output logic                   clear_done,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t             state_reg, state_next;
    logic [WADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic               act_reg, act_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   stride_reg, stride_next;
    logic [IDX_W-1:0]   mask_reg, mask_next;
    logic [CNT_W-1:0]   left_reg, left_next;
    logic               ans_reg, ans_next;
    logic               d_valid_reg, d_valid_next;
    logic               d_last_reg, d_last_next;
    logic [WADDR_W-1:0] d_addr_reg, d_addr_next;
    logic [BIT_W-1:0]   d_bit_reg, d_bit_next;
    logic               fw_valid_reg, fw_valid_next;
    logic [WADDR_W-1:0] fw_addr_reg, fw_addr_next;
    logic [WORD_W-1:0]  fw_data_reg, fw_data_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_ans_reg, out_ans_next;

    logic               ram_we;
    logic [WADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [WADDR_W-1:0] ram_raddr;
    logic [WORD_W-1:0]  ram_rdata;
    logic [IDX_W-1:0]   idx_masked;
    logic [WORD_W-1:0]  word;
    logic               hit;
    logic               out_free;

    bfiq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_masked = idx_reg & mask_reg;
    assign ram_raddr  = idx_masked[IDX_W-1:BIT_W];
    // the word written last cycle is not yet visible in the read data
    assign word = (fw_valid_reg && (fw_addr_reg == d_addr_reg)) ? fw_data_reg : ram_rdata;
    assign hit  = word[d_bit_reg];
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        act_next       = act_reg;
        idx_next       = idx_reg;
        stride_next    = stride_reg;
        mask_next      = mask_reg;
        left_next      = left_reg;
        ans_next       = ans_reg;
        d_valid_next   = 1'b0;
        d_last_next    = d_last_reg;
        d_addr_next    = d_addr_reg;
        d_bit_next     = d_bit_reg;
        fw_valid_next  = fw_valid_reg;
        fw_addr_next   = fw_addr_reg;
        fw_data_next   = fw_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_ans_next   = out_ans_reg;
        pop_ready      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = d_addr_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                fw_valid_next = 1'b0;
                clr_addr_next = clr_addr_reg + WADDR_W'(1);
                if (clr_addr_reg == WADDR_W'(WORDS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                pop_ready = out_free;
                if (pop_valid && out_free)
                begin
                    if (pop_job.probes == '0)
                    begin
                        // nothing probed: a query holds, an add changes nothing
                        out_valid_next = 1'b1;
                        out_ans_next   = (pop_job.action == ACT_QUERY);
                    end
                    else
                    begin
                        act_next    = pop_job.action;
                        idx_next    = pop_job.base;
                        stride_next = pop_job.stride;
                        mask_next   = pop_job.mask;
                        left_next   = pop_job.probes;
                        ans_next    = (pop_job.action == ACT_QUERY);
                        state_next  = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // issue one read per cycle
                if (left_reg != '0)
                begin
                    ram_re       = 1'b1;
                    d_valid_next = 1'b1;
                    d_addr_next  = idx_masked[IDX_W-1:BIT_W];
                    d_bit_next   = idx_masked[BIT_W-1:0];
                    d_last_next  = (left_reg == CNT_W'(1));
                    idx_next     = idx_reg + stride_reg;
                    left_next    = left_reg - CNT_W'(1);
                end
                // test, and for an add set, the bit read last cycle
                if (d_valid_reg)
                begin
                    if (act_reg == ACT_ADD)
                    begin
                        ram_we        = 1'b1;
                        ram_wdata     = word | (WORD_W'(1) << d_bit_reg);
                        fw_valid_next = 1'b1;
                        fw_addr_next  = d_addr_reg;
                        fw_data_next  = ram_wdata;
                        ans_next      = ans_reg || !hit;
                    end
                    else
                    begin
                        ans_next = ans_reg && hit;
                    end
                    if (d_last_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_ans_next   = ans_next;
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            act_reg       <= ACT_QUERY;
            idx_reg       <= '0;
            stride_reg    <= '0;
            mask_reg      <= '0;
            left_reg      <= '0;
            ans_reg       <= 1'b0;
            d_valid_reg   <= 1'b0;
            d_last_reg    <= 1'b0;
            d_addr_reg    <= '0;
            d_bit_reg     <= '0;
            fw_valid_reg  <= 1'b0;
            fw_addr_reg   <= '0;
            fw_data_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_ans_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            act_reg       <= act_next;
            idx_reg       <= idx_next;
            stride_reg    <= stride_next;
            mask_reg      <= mask_next;
            left_reg      <= left_next;
            ans_reg       <= ans_next;
            d_valid_reg   <= d_valid_next;
            d_last_reg    <= d_last_next;
            d_addr_reg    <= d_addr_next;
            d_bit_reg     <= d_bit_next;
            fw_valid_reg  <= fw_valid_next;
            fw_addr_reg   <= fw_addr_next;
            fw_data_reg   <= fw_data_next;
            out_valid_reg <= out_valid_next;
            out_ans_reg   <= out_ans_next;
        end
    end

    assign clear_done = (state_reg != ST_CLEAR);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {{(OUT_TDATA_W - 1){1'b0}}, out_ans_reg};

endmodule

// ===== rtl/bfiq_checker.sv =====
// port-level checker for the bloom filter block, bound to the top level
module bfiq_checker
    import bfiq_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int PEND_W = $clog2(CAPACITY + 1);

    logic [PEND_W-1:0] pend_reg;
    logic              in_beat;
    logic              out_beat;

    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    // items accepted whose result has not yet been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (in_beat && !out_beat)
            pend_reg <= pend_reg + PEND_W'(1);
        else if (out_beat && !in_beat)
            pend_reg <= pend_reg - PEND_W'(1);
    end

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    // registers settle at the first reset edge, so the check is made only after that edge
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !s_tready && !m_tvalid)
        else $error("handshake active in reset");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pend_reg != '0)
        else $error("result without a pending item");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == PEND_W'(CAPACITY) |-> !s_tready)
        else $error("beat accepted beyond internal capacity");

endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (.*);

// ===== verif/testbench.sv =====
// self-checking testbench of the bloom filter insert/query block
module testbench;
    import bfiq_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = MAX_PROBES + 8;
    localparam int          PHASES       = 14;
    localparam int          PHASE_ITEMS  = 110;
    localparam int          POOL_SIZE    = 256;
    localparam int          PLAN_ROWS    = 23;
    localparam logic [63:0] FP_ZERO      = 64'd0;
    localparam logic [63:0] FP_ONES      = {64{1'b1}};
    // register indexes the block has no register behind
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

    // one directed row: optional filter setting, then one item
    typedef struct packed {
        bit          set_cfg;
        bit [5:0]    probes;
        bit [5:0]    log_val;
        logic        action;
        logic [63:0] lo;
        logic [63:0] hi;
        bit          typed;    // answer below is known without the predictor
        logic        answer;
    } plan_row_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic                   s_tuser   = ACT_QUERY;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // predictor state: its own copy of the store and of the registers
    bit          filter_bits [2**MAX_LOG_BITS];
    bit [5:0]    probe_setting = 6'd1;
    bit [4:0]    log_setting   = 5'd16;
    logic        answers_due [$];
    logic [63:0] pool_lo [POOL_SIZE];
    logic [63:0] pool_hi [POOL_SIZE];
    int          pool_n        = 0;
    int          cycle_count   = 0;
    int          error_count   = 0;
    int          items_sent    = 0;
    int          adds_sent     = 0;
    int          answers_seen  = 0;
    int          query_hits    = 0;
    int          settings_used = 0;
    bit          steady        = 1'b0;

    plan_row_t plan_rows [PLAN_ROWS] = '{
        // reset setting: one probe over the full store, store empty
        '{1'b0, 6'd0, 6'd0, ACT_QUERY, FP_ZERO, FP_ZERO, 1'b1, 1'b0},
        '{1'b0, 6'd0, 6'd0, ACT_QUERY, FP_ONES, FP_ONES, 1'b1, 1'b0},
        '{1'b0, 6'd0, 6'd0, ACT_ADD,   FP_ZERO, FP_ZERO, 1'b1, 1'b1},
        '{1'b0, 6'd0, 6'd0, ACT_ADD,   FP_ZERO, FP_ONES, 1'b1, 1'b0},
        '{1'b0, 6'd0, 6'd0, ACT_QUERY, FP_ZERO, 64'h1234, 1'b1, 1'b1},
        '{1'b0, 6'd0, 6'd0, ACT_ADD,   FP_ONES, FP_ONES, 1'b1, 1'b1},
        '{1'b0, 6'd0, 6'd0, ACT_QUERY, FP_ONES, FP_ZERO, 1'b1, 1'b1},
        // zero probes: query always hits, add never changes a bit
        '{1'b1, 6'd0, 6'd9, ACT_QUERY, 64'h0123_4567_89AB_CDEF,
          64'hFEDC_BA98_7654_3210, 1'b1, 1'b1},
        '{1'b1, 6'd0, 6'd9, ACT_ADD,   64'h0123_4567_89AB_CDEF,
          64'hFEDC_BA98_7654_3210, 1'b1, 1'b0},
        // probe count above the maximum, log below the minimum, zero stride
        // so every probe lands on the same bit
        '{1'b1, 6'd63, 6'd0, ACT_ADD,   64'd5, FP_ZERO, 1'b1, 1'b1},
        '{1'b0, 6'd0,  6'd0, ACT_QUERY, 64'd5, FP_ZERO, 1'b1, 1'b1},
        '{1'b0, 6'd0,  6'd0, ACT_ADD,   64'd5, FP_ZERO, 1'b1, 1'b0},
        // stride sum wraps past 2^64
        '{1'b0, 6'd0,  6'd0, ACT_ADD,   FP_ONES, 64'd1, 1'b0, 1'b0},
        '{1'b0, 6'd0,  6'd0, ACT_QUERY, FP_ONES, FP_ONES, 1'b0, 1'b0},
        // log above the maximum
        '{1'b1, 6'd32, 6'd31, ACT_ADD,   64'h8000_0000_0000_0000,
          64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
        '{1'b0, 6'd0,  6'd0,  ACT_QUERY, 64'h8000_0000_0000_0000,
          64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
        // back to the reset setting: top bit of the store was set early on
        '{1'b1, 6'd1,  6'd16, ACT_QUERY, FP_ONES, FP_ZERO, 1'b1, 1'b1},
        // register bit 5 of log is dropped: 40 reads as 8, 63 as 31
        '{1'b1, 6'd17, 6'd40, ACT_ADD,   64'hDEAD_BEEF_0BAD_F00D,
          64'h0000_0001_0000_0003, 1'b0, 1'b0},
        '{1'b0, 6'd0,  6'd0,  ACT_QUERY, 64'hDEAD_BEEF_0BAD_F00D,
          64'h0000_0001_0000_0003, 1'b0, 1'b0},
        '{1'b1, 6'd2,  6'd63, ACT_ADD,   64'hAAAA_AAAA_AAAA_AAAA,
          64'h5555_5555_5555_5555, 1'b0, 1'b0},
        '{1'b0, 6'd0,  6'd0,  ACT_QUERY, 64'hAAAA_AAAA_AAAA_AAAA,
          64'h5555_5555_5555_5555, 1'b0, 1'b0},
        '{1'b1, 6'd5,  6'd12, ACT_QUERY, FP_ZERO, FP_ONES, 1'b0, 1'b0},
        '{1'b0, 6'd0,  6'd0,  ACT_ADD,   FP_ZERO, FP_ONES, 1'b0, 1'b0}
    };

    bloom_filter_insert_query DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // runs one item through the predicted filter: returns the expected answer
    // and updates the predicted store for an add
    function automatic logic filter_apply(input logic act, input logic [63:0] lo,
                                          input logic [63:0] hi);
        logic [63:0] mask;
        logic [63:0] idx;
        int          n;
        int          lg;
        logic        ans;
        lg = log_setting;
        if (lg < MIN_LOG_BITS)
            lg = MIN_LOG_BITS;
        if (lg > MAX_LOG_BITS)
            lg = MAX_LOG_BITS;
        n = (probe_setting > MAX_PROBES) ? MAX_PROBES : probe_setting;
        mask = (64'd1 << lg) - 64'd1;
        ans = (act == ACT_QUERY);
        for (int i = 0; i < n; i++)
        begin
            idx = (lo + hi * 64'(i)) & mask;
            if (act == ACT_QUERY)
            begin
                if (!filter_bits[idx[MAX_LOG_BITS-1:0]])
                begin
                    ans = 1'b0;
                    break;
                end
            end
            else if (!filter_bits[idx[MAX_LOG_BITS-1:0]])
            begin
                // a repeated index only counts on its first hit
                filter_bits[idx[MAX_LOG_BITS-1:0]] = 1'b1;
                ans = 1'b1;
            end
        end
        return ans;
    endfunction

    function automatic logic [63:0] rand_fp();
        return {$urandom, $urandom};
    endfunction

    // waits for every outstanding answer plus the pipeline tail, then writes
    // both registers and the two unused indexes, which must have no effect
    task automatic set_filter(input bit [5:0] probes, input bit [5:0] log_val);
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PROBE_COUNT;
        cfg_data  <= probes;
        @(posedge clk);
        cfg_index <= REG_LOG_BITS;
        cfg_data  <= log_val;
        @(posedge clk);
        cfg_index <= REG_SPARE_A;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_index <= REG_SPARE_B;
        cfg_data  <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        probe_setting = probes;
        log_setting   = log_val[4:0];
        settings_used++;
    endtask

    // offers one beat, with random idle cycles ahead of it outside the steady
    // stretch, and queues the expected answer once the beat is taken
    task automatic send_item(input logic act, input logic [63:0] lo,
                             input logic [63:0] hi, input bit typed,
                             input logic typed_ans);
        logic predicted;
        predicted = filter_apply(act, lo, hi);
        while (!steady && $urandom_range(99) < 32)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {hi, lo};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        answers_due.push_back(typed ? typed_ans : predicted);
        items_sent++;
        if (act == ACT_ADD)
            adds_sent++;
    endtask

    task automatic remember_fp(input logic [63:0] lo, input logic [63:0] hi);
        int slot;
        slot = (pool_n < POOL_SIZE) ? pool_n : $urandom_range(POOL_SIZE - 1);
        pool_lo[slot] = lo;
        pool_hi[slot] = hi;
        if (pool_n < POOL_SIZE)
            pool_n++;
    endtask

    // result side: random back-pressure, none during the steady stretch
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99) >= 32);

    // every answer beat is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (answers_due.size() == 0)
            begin
                $error("answer beat with no item outstanding: actual %0b", m_tdata[0]);
                error_count++;
            end
            else
            begin
                if (m_tdata[0] !== answers_due[0])
                begin
                    $error("answer mismatch: expected %0b, actual %0b",
                           answers_due[0], m_tdata[0]);
                    error_count++;
                end
                void'(answers_due.pop_front());
                answers_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] lo;
        logic [63:0] hi;
        logic        act;
        int          r;
        int          slot;
        bit [5:0]    pc;
        bit [5:0]    lb;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed part: the first rows run with the reset setting
        for (int row = 0; row < PLAN_ROWS; row++)
        begin
            if (plan_rows[row].set_cfg)
                set_filter(plan_rows[row].probes, plan_rows[row].log_val);
            send_item(plan_rows[row].action, plan_rows[row].lo, plan_rows[row].hi,
                      plan_rows[row].typed, plan_rows[row].answer);
        end

        // random part: one filter setting per phase, extremes first
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin pc = 6'd1;  lb = 6'd9;  end
                1: begin pc = 6'd32; lb = 6'd9;  end
                2: begin pc = 6'd3;  lb = 6'd16; end
                3: begin pc = 6'd0;  lb = 6'd16; end
                default:
                begin
                    case ($urandom_range(7))
                        0, 1, 2: pc = 6'($urandom_range(4, 1));
                        3:       pc = 6'($urandom_range(31, 5));
                        4:       pc = 6'd32;
                        5:       pc = 6'($urandom_range(63, 33));
                        6:       pc = 6'd0;
                        default: pc = 6'($urandom_range(63, 1));
                    endcase
                    case ($urandom_range(5))
                        0:       lb = 6'($urandom_range(8, 0));
                        1:       lb = 6'($urandom_range(16, 9));
                        2:       lb = 6'd9;
                        3:       lb = 6'd16;
                        4:       lb = 6'($urandom_range(31, 17));
                        default: lb = 6'($urandom_range(63, 32));
                    endcase
                end
            endcase
            // the setting change also drains the block: the sender pauses
            // until every expected answer is back
            set_filter(pc, lb);
            steady <= (phase == 5);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(99);
                if (r < 40 || pool_n == 0)
                begin
                    // fresh add, sometimes with a degenerate stride
                    act = ACT_ADD;
                    lo  = rand_fp();
                    case ($urandom_range(15))
                        0:       hi = FP_ZERO;
                        1:       hi = FP_ONES;
                        default: hi = rand_fp();
                    endcase
                    remember_fp(lo, hi);
                end
                else
                begin
                    // re-add or query of a known fingerprint, or a stray query
                    slot = $urandom_range(pool_n - 1);
                    act  = (r < 55) ? ACT_ADD : ACT_QUERY;
                    lo   = (r < 85) ? pool_lo[slot] : rand_fp();
                    hi   = (r < 85) ? pool_hi[slot] : rand_fp();
                end
                if (act == ACT_QUERY && filter_apply(act, lo, hi))
                    query_hits++;
                send_item(act, lo, hi, 1'b0, 1'b0);
            end
        end

        s_tvalid <= 1'b0;
        steady   <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d items (%0d adds, %0d queries, %0d query hits) over %0d settings",
                 items_sent, adds_sent, items_sent - adds_sent, query_hits, settings_used);
        $display("checked %0d answers, %0d mismatches", answers_seen, error_count);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bfiq_pkg.sv
rtl/bfiq_ram.sv
rtl/bfiq_front.sv
rtl/bfiq_queue.sv
rtl/bfiq_back.sv
rtl/bloom_filter_insert_query.sv
rtl/bfiq_checker.sv
verif/testbench.sv
